/* sv/obrb_pkg.sv */
// ----------------------------------------------------------------------------
// obrb_pkg: overwriting byte ring buffer shared definitions
// request and status codes, field widths and controller command group
// ----------------------------------------------------------------------------
`default_nettype none

package obrb_pkg;

	localparam int unsigned IDX_W  = 32;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned FILL_W = 9;

	// head and tail start at 2^32 - 500
	localparam logic [IDX_W-1:0] RESET_INDEX = 32'hFFFF_FE0C;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_WRITE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RETRY   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/obrb_req_if.sv */
// ----------------------------------------------------------------------------
// obrb_req_if: request channel
// valid/ready handshake carrying one ring buffer request
// ----------------------------------------------------------------------------
`default_nettype none

interface obrb_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [obrb_pkg::DATA_W-1:0]   data_byte;
	logic                          overwrite;
	logic [obrb_pkg::IDX_W-1:0]    req_index;

	modport source (output valid, output req_type, output data_byte,
		output overwrite, output req_index, input ready);
	modport sink (input valid, input req_type, input data_byte,
		input overwrite, input req_index, output ready);
endinterface

`default_nettype wire

/* sv/obrb_rsp_if.sv */
// ----------------------------------------------------------------------------
// obrb_rsp_if: response channel
// valid/ready handshake carrying one ring buffer result
// ----------------------------------------------------------------------------
`default_nettype none

interface obrb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [obrb_pkg::DATA_W-1:0]   read_data;
	logic [obrb_pkg::FILL_W-1:0]   fill_level;

	modport source (output valid, output status, output read_data,
		output fill_level, input ready);
	modport sink (input valid, input status, input read_data,
		input fill_level, output ready);
endinterface

`default_nettype wire

/* sv/obrb_ctrl.sv */
// ----------------------------------------------------------------------------
// obrb_ctrl: request sequencer
// takes a request, runs the execute step, holds the result until taken
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output obrb_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_RESP);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.exec    = (state_q == S_EXEC);

endmodule

`default_nettype wire

/* sv/obrb_datapath.sv */
// ----------------------------------------------------------------------------
// obrb_datapath: ring buffer storage and index arithmetic
// holds head/tail indices, byte memory and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module obrb_datapath #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire obrb_pkg::cmd_t                cmd,
	input  wire logic [1:0]                    req_type,
	input  wire logic [obrb_pkg::DATA_W-1:0]   data_byte,
	input  wire logic                          overwrite,
	input  wire logic [obrb_pkg::IDX_W-1:0]    req_index,
	output logic [1:0]                         status,
	output logic [obrb_pkg::DATA_W-1:0]        read_data,
	output logic [obrb_pkg::FILL_W-1:0]        fill_level
);

	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam logic [obrb_pkg::IDX_W-1:0] CAP_IDX = obrb_pkg::IDX_W'(CAPACITY);

	// captured request
	obrb_pkg::req_type_t             req_q;
	logic [obrb_pkg::DATA_W-1:0]     data_q;
	logic                            ovw_q;
	logic [obrb_pkg::IDX_W-1:0]      idx_q;

	logic [obrb_pkg::IDX_W-1:0]      head_q;
	logic [obrb_pkg::IDX_W-1:0]      tail_q;

	logic [obrb_pkg::DATA_W-1:0]     mem_q [CAPACITY];
	logic [obrb_pkg::DATA_W-1:0]     rd_data_q;
	logic                            rd_ok_q;
	obrb_pkg::status_t               status_q;
	logic [obrb_pkg::FILL_W-1:0]     fill_q;

	logic [obrb_pkg::IDX_W-1:0]      held;
	logic [obrb_pkg::IDX_W-1:0]      offset;
	logic                            full;
	logic [obrb_pkg::IDX_W-1:0]      head_n;
	logic [obrb_pkg::IDX_W-1:0]      tail_n;
	logic [obrb_pkg::IDX_W-1:0]      fill_n;
	obrb_pkg::status_t               status_n;
	logic                            wr_en;
	logic                            rd_en;
	logic [ADDR_W-1:0]               mem_addr;

	assign held   = tail_q - head_q;
	assign offset = idx_q - head_q;
	assign full   = (held >= CAP_IDX);

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		status_n = obrb_pkg::ST_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		mem_addr = idx_q[ADDR_W-1:0];
		unique case (req_q)
			obrb_pkg::REQ_PUSH: begin
				mem_addr = tail_q[ADDR_W-1:0];
				if (!ovw_q && full) begin
					status_n = obrb_pkg::ST_RETRY;
				end else begin
					wr_en  = 1'b1;
					tail_n = tail_q + 1'b1;
					if (full) begin
						head_n = head_q + 1'b1;
					end
				end
			end
			obrb_pkg::REQ_POP: begin
				mem_addr = head_q[ADDR_W-1:0];
				if (held == '0) begin
					status_n = obrb_pkg::ST_RETRY;
				end else begin
					rd_en  = 1'b1;
					head_n = head_q + 1'b1;
				end
			end
			obrb_pkg::REQ_READ: begin
				if (offset < held) begin
					rd_en = 1'b1;
				end else begin
					status_n = obrb_pkg::ST_INVALID;
				end
			end
			obrb_pkg::REQ_WRITE: begin
				if (offset <= held) begin
					wr_en = 1'b1;
					// write at the tail appends, dropping the oldest when full
					if (idx_q == tail_q) begin
						tail_n = tail_q + 1'b1;
						if (full) begin
							head_n = head_q + 1'b1;
						end
					end
				end else begin
					status_n = obrb_pkg::ST_INVALID;
				end
			end
			default: begin
				status_n = obrb_pkg::ST_INVALID;
			end
		endcase
	end

	assign fill_n = tail_n - head_n;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= obrb_pkg::req_type_t'(req_type);
			data_q <= data_byte;
			ovw_q  <= overwrite;
			idx_q  <= req_index;
		end
		if (cmd.exec) begin
			rd_ok_q  <= rd_en;
			status_q <= status_n;
			fill_q   <= fill_n[obrb_pkg::FILL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= obrb_pkg::RESET_INDEX;
			tail_q <= obrb_pkg::RESET_INDEX;
		end else if (cmd.exec) begin
			head_q <= head_n;
			tail_q <= tail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[mem_addr] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && rd_en) begin
			rd_data_q <= mem_q[mem_addr];
		end
	end

	assign status     = status_q;
	assign read_data  = rd_ok_q ? rd_data_q : '0;
	assign fill_level = fill_q;

endmodule

`default_nettype wire

/* sv/overwriting_byte_ring_buffer_top.sv */
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_top: byte ring buffer with overwrite
// push, pop, read-at and write-at on a power-of-two byte store
// ----------------------------------------------------------------------------
// a request is taken, executed against the single-port byte memory, and its result
// held until the response side takes it; the next request is accepted only after that
// reset: head and tail indices go to 2^32 - 500, buffer empty, no clearing pass
`default_nettype none

module overwriting_byte_ring_buffer_top #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	obrb_req_if.sink   req,
	obrb_rsp_if.source rsp
);

	obrb_pkg::cmd_t cmd;

	obrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	obrb_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req.req_type),
		.data_byte  (req.data_byte),
		.overwrite  (req.overwrite),
		.req_index  (req.req_index),
		.status     (rsp.status),
		.read_data  (rsp.read_data),
		.fill_level (rsp.fill_level)
	);

endmodule

`default_nettype wire

/* tb/sv/overwriting_byte_ring_buffer_top_tb.sv */
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_top_tb: self-checking bench for the ring buffer
// drives push, pop, read-at and write-at requests with random gaps, predicts
// every result from a local copy of the indices and bytes, and compares each
// response field by field in request order
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_byte_ring_buffer_top_tb;

	localparam int unsigned RING_DEPTH   = 256;
	localparam int unsigned RING_AW      = $clog2(RING_DEPTH);
	localparam int unsigned RANDOM_REQS  = 1050;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned LONG_HOLD    = 64;
	localparam int unsigned HOLD_START_A = 900;
	localparam int unsigned HOLD_START_B = 3000;

	// how the index of a read or write request is formed when it is driven
	typedef enum logic [1:0] {
		BASE_ABS,
		BASE_HEAD,
		BASE_TAIL
	} idx_base_t;

	typedef struct {
		obrb_pkg::req_type_t          kind;
		logic [7:0]                   data;
		logic                         ovw;
		idx_base_t                    base;
		logic [obrb_pkg::IDX_W-1:0]   index;
		logic                         sync;
	} byte_req_t;

	typedef struct {
		obrb_pkg::status_t            status;
		logic [7:0]                   data;
		logic [obrb_pkg::FILL_W-1:0]  fill;
	} ring_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	obrb_req_if req_ch ();
	obrb_rsp_if rsp_ch ();

	overwriting_byte_ring_buffer_top #(
		.CAPACITY(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted buffer state
	logic [obrb_pkg::IDX_W-1:0] ring_head;
	logic [obrb_pkg::IDX_W-1:0] ring_tail;
	logic [7:0]                 ring_bytes [RING_DEPTH];

	byte_req_t  pending_reqs [$];
	ring_rsp_t  expected_rsp [0:4095];
	int         n_sent;
	int         n_recv;
	int         errors;
	int         cycle_count;

	function automatic byte_req_t make_req(obrb_pkg::req_type_t k, logic [7:0] d,
		logic o, idx_base_t b, logic [obrb_pkg::IDX_W-1:0] x, logic s);
		byte_req_t r;
		r.kind  = k;
		r.data  = d;
		r.ovw   = o;
		r.base  = b;
		r.index = x;
		r.sync  = s;
		return r;
	endfunction

	// drop oldest bytes so that at most RING_DEPTH remain
	task automatic trim_ring();
		if (ring_tail - ring_head > RING_DEPTH)
			ring_head = ring_tail - RING_DEPTH;
	endtask

	task automatic apply_request(input byte_req_t r, output ring_rsp_t res);
		logic [obrb_pkg::IDX_W-1:0] held;
		logic [obrb_pkg::IDX_W-1:0] rel;
		logic [obrb_pkg::IDX_W-1:0] fill_all;
		held       = ring_tail - ring_head;
		rel        = r.index - ring_head;
		res.status = obrb_pkg::ST_OK;
		res.data   = 8'd0;
		case (r.kind)
			obrb_pkg::REQ_PUSH: begin
				if (!r.ovw && held >= RING_DEPTH) begin
					res.status = obrb_pkg::ST_RETRY;
				end else begin
					ring_bytes[ring_tail[RING_AW-1:0]] = r.data;
					ring_tail++;
					trim_ring();
				end
			end
			obrb_pkg::REQ_POP: begin
				if (held == 0) begin
					res.status = obrb_pkg::ST_RETRY;
				end else begin
					res.data = ring_bytes[ring_head[RING_AW-1:0]];
					ring_head++;
				end
			end
			obrb_pkg::REQ_READ: begin
				if (rel < held)
					res.data = ring_bytes[r.index[RING_AW-1:0]];
				else
					res.status = obrb_pkg::ST_INVALID;
			end
			default: begin
				if (rel <= held) begin
					ring_bytes[r.index[RING_AW-1:0]] = r.data;
					// write at tail appends like an overwriting push
					if (r.index == ring_tail) begin
						ring_tail++;
						trim_ring();
					end
				end else begin
					res.status = obrb_pkg::ST_INVALID;
				end
			end
		endcase
		fill_all = ring_tail - ring_head;
		res.fill = fill_all[obrb_pkg::FILL_W-1:0];
	endtask

	// request driver
	byte_req_t   cur_req;
	int unsigned tx_wait;
	bit          tx_steady;

	always @(posedge clk) begin
		bit        took;
		ring_rsp_t want;
		if (arst_n) begin
			took = req_ch.valid && req_ch.ready;
			if (took) begin
				apply_request(cur_req, want);
				expected_rsp[n_sent] = want;
				n_sent <= n_sent + 1;
				if ($urandom_range(0, 39) == 0)
					tx_steady = !tx_steady;
				tx_wait = tx_steady ? 0 : $urandom_range(0, 5);
			end
			if (took || !req_ch.valid) begin
				if (tx_wait != 0) begin
					tx_wait--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						(!pending_reqs[0].sync || n_recv == n_sent + took)) begin
					cur_req = pending_reqs.pop_front();
					// resolve relative indices against the state after the last request
					case (cur_req.base)
						BASE_HEAD: cur_req.index = ring_head + cur_req.index;
						BASE_TAIL: cur_req.index = ring_tail + cur_req.index;
						default: ;
					endcase
					cur_req.base = BASE_ABS;
					req_ch.req_type  <= cur_req.kind;
					req_ch.data_byte <= cur_req.data;
					req_ch.overwrite <= cur_req.ovw;
					req_ch.req_index <= cur_req.index;
					req_ch.valid     <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver holds let requests back up behind a waiting result
	int unsigned hold_left;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cycle_count == HOLD_START_A || cycle_count == HOLD_START_B)
				hold_left <= LONG_HOLD;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	// response monitor
	int unsigned rx_wait;
	bit          rx_steady;

	always @(posedge clk) begin
		ring_rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (n_recv >= n_sent) begin
					errors++;
					$display("%0t: unexpected result, expected none, got status %0d",
						$time, rsp_ch.status);
				end else begin
					want = expected_rsp[n_recv];
					if (rsp_ch.status !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
					end
					if (rsp_ch.read_data !== want.data) begin
						errors++;
						$display("%0t: read_data mismatch, expected %0d, got %0d",
							$time, want.data, rsp_ch.read_data);
					end
					if (rsp_ch.fill_level !== want.fill) begin
						errors++;
						$display("%0t: fill_level mismatch, expected %0d, got %0d",
							$time, want.fill, rsp_ch.fill_level);
					end
					n_recv <= n_recv + 1;
				end
				if ($urandom_range(0, 39) == 0)
					rx_steady = !rx_steady;
				rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
			end
			if (rx_wait != 0) begin
				rx_wait--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (hold_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n_rand;
		int unsigned seg_len;
		int unsigned mode;
		int unsigned pick;
		int unsigned sel;
		int unsigned t_push;
		int unsigned t_pop;
		int unsigned t_read;
		obrb_pkg::req_type_t        kind;
		idx_base_t                  base;
		logic [obrb_pkg::IDX_W-1:0] off;
		logic        ovw;
		logic        sync;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = obrb_pkg::REQ_PUSH;
		req_ch.data_byte = 8'd0;
		req_ch.overwrite = 1'b0;
		req_ch.req_index = '0;
		rsp_ch.ready     = 1'b0;
		ring_head        = obrb_pkg::RESET_INDEX;
		ring_tail        = obrb_pkg::RESET_INDEX;
		n_sent           = 0;
		n_recv           = 0;
		errors           = 0;
		cycle_count      = 0;
		tx_wait          = 0;
		tx_steady        = 1'b0;
		rx_wait          = 0;
		rx_steady        = 1'b0;
		hold_left        = 0;

		// empty buffer: pop, read and out-of-range write all fail
		pending_reqs.push_back(make_req(obrb_pkg::REQ_POP,   8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'h11, 1'b0, BASE_HEAD,
			32'd1, 1'b0));
		// write at tail appends, then pushes with both overwrite settings
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'hFF, 1'b0, BASE_TAIL,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_PUSH,  8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_PUSH,  8'hA5, 1'b1, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_HEAD,
			32'd2, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_TAIL,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_ABS,
			32'hFFFF_FFFF, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_ABS,
			32'h0000_0000, 1'b0));
		// overwrite inside the held range, then writes outside it and pops past empty
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'h5A, 1'b0, BASE_HEAD,
			32'd1, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b0, BASE_HEAD,
			32'd1, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'h3C, 1'b1, BASE_ABS,
			32'hFFFF_FFFF, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'hC3, 1'b0, BASE_HEAD,
			32'hFFFF_FFFF, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_WRITE, 8'h77, 1'b0, BASE_TAIL,
			32'd1, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_READ,  8'h00, 1'b1, BASE_ABS,
			32'h8000_0000, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_POP,   8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_POP,   8'hFF, 1'b1, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_POP,   8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_POP,   8'h00, 1'b0, BASE_HEAD,
			32'd0, 1'b0));
		pending_reqs.push_back(make_req(obrb_pkg::REQ_PUSH,  8'h81, 1'b1, BASE_HEAD,
			32'd0, 1'b0));

		// random segments, each leaning toward filling, draining or thrashing
		n_rand = 0;
		while (n_rand < RANDOM_REQS) begin
			seg_len = $urandom_range(40, 160);
			mode    = $urandom_range(0, 3);
			case (mode)
				0: begin t_push = 55; t_pop = 65; t_read = 82; end
				1: begin t_push = 15; t_pop = 65; t_read = 85; end
				2: begin t_push = 30; t_pop = 55; t_read = 80; end
				default: begin t_push = 60; t_pop = 65; t_read = 80; end
			endcase
			for (int unsigned i = 0; i < seg_len && n_rand < RANDOM_REQS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < t_push)
					kind = obrb_pkg::REQ_PUSH;
				else if (pick < t_pop)
					kind = obrb_pkg::REQ_POP;
				else if (pick < t_read)
					kind = obrb_pkg::REQ_READ;
				else
					kind = obrb_pkg::REQ_WRITE;
				ovw = (mode == 3) ? ($urandom_range(0, 99) < 85) : 1'($urandom_range(0, 1));
				sel = $urandom_range(0, 9);
				if (mode == 3 && kind == obrb_pkg::REQ_WRITE && $urandom_range(0, 1) == 1)
					sel = 6;
				case (sel)
					6:       begin base = BASE_TAIL; off = 32'd0; end
					7:       begin base = BASE_TAIL; off = $urandom_range(1, 3); end
					8:       begin base = BASE_HEAD; off = -$urandom_range(1, 3); end
					9:       begin base = BASE_ABS;  off = $urandom; end
					default: begin base = BASE_HEAD; off = $urandom_range(0, 260); end
				endcase
				// the sender waits for every result at the start and midway
				sync = (n_rand == 0 || n_rand == RANDOM_REQS / 2);
				pending_reqs.push_back(make_req(kind, 8'($urandom), ovw, base, off, sync));
				n_rand++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || n_recv != n_sent);
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
